[hdl/cbm_pkg.sv]
package cbm_pkg;

    // Field widths of the block address and the results.
    localparam int ADDR_W = 17;
    localparam int BIS_W  = 5;
    localparam int L2I_W  = 6;
    localparam int L1I_W  = 6;
    localparam int TBL_W  = 6;
    localparam int SLOT_W = 13;

    localparam int BLOCKS_PER_SLOT = 32;
    localparam int L1_ENTRIES      = 64;
    localparam int L2_ENTRIES      = 64;
    localparam int L2_TABLES       = 64;

    // Slot allocation stops once the counter reaches this value.
    localparam logic [SLOT_W-1:0] SLOT_LIMIT = 13'd8191;

    // One L2 entry: slot assignment plus one bit per block in the slot.
    typedef struct packed {
        logic                       has_slot;
        logic [SLOT_W-1:0]          slot;
        logic [BLOCKS_PER_SLOT-1:0] bits;
    } entry_t;

    // Request kinds.
    typedef enum logic {
        KIND_READ  = 1'b0,
        KIND_WRITE = 1'b1
    } kind_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_L1,
        ST_CLR,
        ST_L2,
        ST_MOD
    } state_t;

endpackage

[hdl/cbm_entry_upd.sv]
module cbm_entry_upd (
    input  cbm_pkg::entry_t                   ent_in,
    input  logic                              kind,
    input  logic [cbm_pkg::BIS_W-1:0]         bis,
    input  logic [cbm_pkg::SLOT_W-1:0]        next_slot,
    output cbm_pkg::entry_t                   ent_out,
    output logic                              alloc,
    output logic                              hit
);
    import cbm_pkg::*;

    logic [BLOCKS_PER_SLOT-1:0] mask;
    entry_t                     ent;

    // Allocate a missing slot, then set the block bit on a write.
    always_comb begin
        ent   = ent_in;
        mask  = BLOCKS_PER_SLOT'(1) << bis;
        alloc = !ent_in.has_slot && (next_slot != SLOT_LIMIT);
        if (alloc) begin
            ent.has_slot = 1'b1;
            ent.slot     = next_slot;
        end
        if (ent.has_slot && (kind == KIND_WRITE)) begin
            ent.bits = ent.bits | mask;
        end
        hit     = ent.has_slot && (|(ent.bits & mask));
        ent_out = ent;
    end

endmodule

[hdl/cow_block_map_top.sv]
// A request with an existing L2 table passes through the L1 lookup, the L2 read
// and the update; a write that creates a table first sweeps the new table clear.
// A read without a table, or a write that finds no free table, has its result
// made in the L1 lookup state. A new request is taken only in the idle state, once
// the previous result is registered; a result not yet taken holds the update.
// Synchronous active-low reset clears the L1 valid bits and the counters.
module cow_block_map_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_kind,
    input  logic [cbm_pkg::ADDR_W-1:0]        s_block_address,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_is_local,
    output logic [cbm_pkg::SLOT_W-1:0]        m_slot,
    output logic [cbm_pkg::BIS_W-1:0]         m_block_in_slot,
    output logic                              m_table_full
);
    import cbm_pkg::*;

    localparam int L2A_W = TBL_W + L2I_W;

    // Sequencer and counters.
    state_t                 state_reg, state_next;
    logic [TBL_W:0]         next_tbl_reg, next_tbl_next;
    logic [SLOT_W-1:0]      next_slot_reg, next_slot_next;
    logic [L2I_W-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [L1_ENTRIES-1:0]  l1_valid_reg, l1_valid_next;

    // Request and table registers.
    logic                   kind_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic [TBL_W-1:0]       tbl_reg, tbl_next;

    // Result register.
    logic                   m_valid_reg, m_valid_next;
    logic                   is_local_reg, is_local_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic [BIS_W-1:0]       bis_reg, bis_next;
    logic                   full_reg, full_next;

    // Memories.
    logic [TBL_W-1:0]       l1_mem [L1_ENTRIES];
    logic [TBL_W-1:0]       l1_q;
    logic                   l1_we;
    entry_t                 l2_mem [L2_TABLES*L2_ENTRIES];
    entry_t                 l2_q;
    logic                   l2_we;
    logic [L2A_W-1:0]       l2_waddr;
    entry_t                 l2_wdata;

    // Address fields of the held request.
    logic [BIS_W-1:0]       bis;
    logic [L2I_W-1:0]       l2i;
    logic [L1I_W-1:0]       l1i;
    logic                   accept;
    logic                   can_out;

    // Entry update unit outputs.
    entry_t                 upd_ent;
    logic                   upd_alloc;
    logic                   upd_hit;

    assign bis     = addr_reg[BIS_W-1:0];
    assign l2i     = addr_reg[BIS_W +: L2I_W];
    assign l1i     = addr_reg[BIS_W+L2I_W +: L1I_W];
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign can_out = !m_valid_reg || m_ready;

    assign m_valid         = m_valid_reg;
    assign m_is_local      = is_local_reg;
    assign m_slot          = slot_reg;
    assign m_block_in_slot = bis_reg;
    assign m_table_full    = full_reg;

    // L1 table memory, read at the incoming address.
    always_ff @(posedge aclk) begin
        if (l1_we) begin
            l1_mem[l1i] <= next_tbl_reg[TBL_W-1:0];
        end
        l1_q <= l1_mem[s_block_address[BIS_W+L2I_W +: L1I_W]];
    end

    // L2 entry memory, read at the held table and index.
    always_ff @(posedge aclk) begin
        if (l2_we) begin
            l2_mem[l2_waddr] <= l2_wdata;
        end
        l2_q <= l2_mem[{tbl_reg, l2i}];
    end

    cbm_entry_upd u_upd (
        .ent_in    (l2_q),
        .kind      (kind_reg),
        .bis       (bis),
        .next_slot (next_slot_reg),
        .ent_out   (upd_ent),
        .alloc     (upd_alloc),
        .hit       (upd_hit)
    );

    // State and control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            next_tbl_reg  <= '0;
            next_slot_reg <= SLOT_W'(1);
            clr_cnt_reg   <= '0;
            l1_valid_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            next_tbl_reg  <= next_tbl_next;
            next_slot_reg <= next_slot_next;
            clr_cnt_reg   <= clr_cnt_next;
            l1_valid_reg  <= l1_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= s_kind;
            addr_reg <= s_block_address;
        end
        tbl_reg      <= tbl_next;
        is_local_reg <= is_local_next;
        slot_reg     <= slot_next;
        bis_reg      <= bis_next;
        full_reg     <= full_next;
    end

    // Next state and datapath control.
    always_comb begin
        state_next     = state_reg;
        next_tbl_next  = next_tbl_reg;
        next_slot_next = next_slot_reg;
        clr_cnt_next   = clr_cnt_reg;
        l1_valid_next  = l1_valid_reg;
        tbl_next       = tbl_reg;
        m_valid_next   = m_valid_reg;
        is_local_next  = is_local_reg;
        slot_next      = slot_reg;
        bis_next       = bis_reg;
        full_next      = full_reg;
        l1_we          = 1'b0;
        l2_we          = 1'b0;
        l2_waddr       = {tbl_reg, l2i};
        l2_wdata       = upd_ent;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_L1;
                end
            end
            ST_L1: begin
                if (l1_valid_reg[l1i]) begin
                    tbl_next   = l1_q;
                    state_next = ST_L2;
                end else if (kind_reg == KIND_WRITE
                             && next_tbl_reg < (TBL_W+1)'(L2_TABLES)) begin
                    // Create a table and sweep its entries clear.
                    l1_we              = 1'b1;
                    l1_valid_next[l1i] = 1'b1;
                    tbl_next           = next_tbl_reg[TBL_W-1:0];
                    next_tbl_next      = next_tbl_reg + 1'b1;
                    clr_cnt_next       = '0;
                    state_next         = ST_CLR;
                end else if (can_out) begin
                    // No table: empty result, full when a write needed one.
                    m_valid_next  = 1'b1;
                    is_local_next = 1'b0;
                    slot_next     = '0;
                    bis_next      = bis;
                    full_next     = (kind_reg == KIND_WRITE);
                    state_next    = ST_IDLE;
                end
            end
            ST_CLR: begin
                l2_we        = 1'b1;
                l2_waddr     = {tbl_reg, clr_cnt_reg};
                l2_wdata     = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == L2I_W'(L2_ENTRIES - 1)) begin
                    state_next = ST_L2;
                end
            end
            ST_L2: begin
                state_next = ST_MOD;
            end
            ST_MOD: begin
                if (can_out) begin
                    l2_we         = 1'b1;
                    if (upd_alloc) begin
                        next_slot_next = next_slot_reg + 1'b1;
                    end
                    m_valid_next  = 1'b1;
                    is_local_next = upd_hit;
                    slot_next     = upd_ent.has_slot ? upd_ent.slot : '0;
                    bis_next      = bis;
                    full_next     = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The slot counter never wraps to the "no slot" value.
    a_slot_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        next_slot_reg != '0)
        else $error("slot counter reached zero");

    // An accepted request always starts with the L1 lookup.
    a_accept_l1: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_L1)
        else $error("request not followed by L1 lookup");

    // The clear sweep ends after the last entry and moves to the L2 read.
    a_clr_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLR && clr_cnt_reg == L2I_W'(L2_ENTRIES - 1))
        |=> state_reg == ST_L2)
        else $error("clear sweep did not finish");

    // A table is only created while one remains.
    a_tbl_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        next_tbl_reg <= (TBL_W+1)'(L2_TABLES))
        else $error("table counter overran");

endmodule

[verif/cow_block_map_top_tb.sv]
module cow_block_map_top_tb;

    import cbm_pkg::*;

    localparam int RANDOM_REQUESTS = 500;
    localparam int HOLD_CYCLES     = 300;
    localparam int HOLD_AT_RESULT  = 150;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 100;
    localparam int MAX_PRINTED     = 40;

    // One pending request with the idle gap the sender waits before offering it.
    typedef struct {
        kind_t             kind;
        logic [ADDR_W-1:0] addr;
        int unsigned       gap;
    } map_req_t;

    // Expected fields of one result.
    typedef struct packed {
        logic              is_local;
        logic [SLOT_W-1:0] slot;
        logic [BIS_W-1:0]  block_in_slot;
        logic              table_full;
    } map_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_kind = 1'b0;
    logic [ADDR_W-1:0]    s_block_address = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_is_local;
    logic [SLOT_W-1:0]    m_slot;
    logic [BIS_W-1:0]     m_block_in_slot;
    logic                 m_table_full;

    // Shadow copy of the block map.
    logic                 l1_live [L1_ENTRIES];
    logic [TBL_W-1:0]     l1_tbl [L1_ENTRIES];
    entry_t               map_store [L2_TABLES*L2_ENTRIES];
    int                   tables_used;
    logic [SLOT_W-1:0]    slots_next;

    map_req_t             pending_requests[$];
    map_result_t          expected_results[$];
    int unsigned          send_idle = 0;
    int                   recv_wait = 0;
    bit                   hold_done = 1'b0;
    int                   mismatches = 0;
    int                   n_sent = 0;
    int                   n_writes = 0;
    int                   n_results = 0;
    int                   quiet_cycles = 0;

    cow_block_map_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_block_address (s_block_address),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_is_local      (m_is_local),
        .m_slot          (m_slot),
        .m_block_in_slot (m_block_in_slot),
        .m_table_full    (m_table_full)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED) begin
            $display("%0t mismatch: %s", $time, what);
        end
    endtask

    // Applies one request to the shadow map and returns the result it causes.
    function automatic map_result_t map_access(input kind_t kind,
                                               input logic [ADDR_W-1:0] addr);
        map_result_t      r;
        logic [BIS_W-1:0] bis;
        logic [L2I_W-1:0] l2i;
        logic [L1I_W-1:0] l1i;
        bit               have;
        int               idx;
        r   = '0;
        bis = addr[BIS_W-1:0];
        l2i = addr[BIS_W +: L2I_W];
        l1i = addr[BIS_W+L2I_W +: L1I_W];
        r.block_in_slot = bis;
        have = l1_live[l1i];

        // A write behind an empty L1 entry takes and clears a fresh L2 table.
        if (!have && kind == KIND_WRITE) begin
            if (tables_used < L2_TABLES) begin
                for (int i = 0; i < L2_ENTRIES; i++) begin
                    map_store[tables_used*L2_ENTRIES + i] = '0;
                end
                l1_tbl[l1i]  = TBL_W'(tables_used);
                l1_live[l1i] = 1'b1;
                tables_used++;
                have = 1'b1;
            end else begin
                r.table_full = 1'b1;
            end
        end

        // Reads and writes alike allocate a missing slot once the table exists.
        if (have) begin
            idx = int'(l1_tbl[l1i]) * L2_ENTRIES + int'(l2i);
            if (!map_store[idx].has_slot && slots_next < SLOT_LIMIT) begin
                map_store[idx].has_slot = 1'b1;
                map_store[idx].slot     = slots_next;
                slots_next++;
            end
            if (map_store[idx].has_slot) begin
                if (kind == KIND_WRITE) begin
                    map_store[idx].bits[bis] = 1'b1;
                end
                r.slot     = map_store[idx].slot;
                r.is_local = map_store[idx].bits[bis];
            end
        end
        return r;
    endfunction

    function automatic void queue_request(input kind_t kind, input logic [ADDR_W-1:0] addr,
                                          input int unsigned gap);
        map_req_t req;
        req.kind = kind;
        req.addr = addr;
        req.gap  = gap;
        pending_requests.push_back(req);
    endfunction

    // Request driver: predicts on acceptance, then idles or offers the next request.
    always @(posedge aclk) begin : drive_requests
        map_req_t nxt;
        if (!aresetn) begin
            s_valid   <= 1'b0;
            send_idle <= 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(map_access(kind_t'(s_kind), s_block_address));
                n_sent++;
                if (kind_t'(s_kind) == KIND_WRITE) begin
                    n_writes++;
                end
            end
            if (!s_valid || s_ready) begin
                if (send_idle > 0) begin
                    send_idle <= send_idle - 1;
                    s_valid   <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    nxt = pending_requests.pop_front();
                    s_valid         <= 1'b1;
                    s_kind          <= nxt.kind;
                    s_block_address <= nxt.addr;
                    send_idle       <= (pending_requests.size() > 0) ?
                                       pending_requests[0].gap : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each result and draws the receiver's stall.
    always @(posedge aclk) begin : check_results
        map_result_t want;
        int          w;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            recv_wait <= 0;
        end else begin
            w = recv_wait;
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result with no request waiting, slot %0d",
                                              m_slot));
                end else begin
                    want = expected_results.pop_front();
                    if (m_is_local !== want.is_local) begin
                        report_mismatch($sformatf("result %0d is_local %0b, expected %0b",
                                                  n_results, m_is_local, want.is_local));
                    end
                    if (m_slot !== want.slot) begin
                        report_mismatch($sformatf("result %0d slot %0d, expected %0d",
                                                  n_results, m_slot, want.slot));
                    end
                    if (m_block_in_slot !== want.block_in_slot) begin
                        report_mismatch($sformatf("result %0d block_in_slot %0d, expected %0d",
                                                  n_results, m_block_in_slot,
                                                  want.block_in_slot));
                    end
                    if (m_table_full !== want.table_full) begin
                        report_mismatch($sformatf("result %0d table_full %0b, expected %0b",
                                                  n_results, m_table_full, want.table_full));
                    end
                end
                n_results++;
                w = ((n_results % 100) < 25) ? 0 : int'($urandom_range(0, 5));
                // One long hold lets the block back up into its input.
                if (!hold_done && n_results == HOLD_AT_RESULT) begin
                    w = HOLD_CYCLES;
                    hold_done <= 1'b1;
                end
            end else if (w > 0) begin
                w = w - 1;
            end
            recv_wait <= w;
            m_ready   <= (w == 0);
        end
    end

    // Watchdog on cycles in which neither channel moves a request or result.
    always @(posedge aclk) begin
        if (aresetn && !(s_valid && s_ready) && !(m_valid && m_ready)) begin
            quiet_cycles++;
        end else begin
            quiet_cycles = 0;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("[cow_block_map_top] ERROR");
            $finish;
        end
    end

    initial begin
        logic [L1I_W-1:0]  hot_l1 [8];
        logic [ADDR_W-1:0] written[$];
        logic [ADDR_W-1:0] a;
        kind_t             k;
        int unsigned       gap;
        int unsigned       pick;

        for (int i = 0; i < L1_ENTRIES; i++) begin
            l1_live[i] = 1'b0;
            l1_tbl[i]  = '0;
        end
        tables_used = 0;
        slots_next  = 13'd1;

        // Directed part: empty map, first table, bits within one slot, far ends.
        queue_request(KIND_READ,  17'd0,      0);
        queue_request(KIND_READ,  17'h1FFFF,  0);
        queue_request(KIND_WRITE, 17'd0,      0);
        queue_request(KIND_READ,  17'd0,      0);
        queue_request(KIND_READ,  17'd1,      0);
        queue_request(KIND_WRITE, 17'd31,     0);
        queue_request(KIND_READ,  17'd31,     0);
        queue_request(KIND_READ,  17'd32,     0);
        queue_request(KIND_WRITE, 17'h1FFFF,  0);
        queue_request(KIND_READ,  17'h1FFFF,  0);
        queue_request(KIND_READ,  17'h1FFE0,  0);
        queue_request(KIND_WRITE, 17'h007FF,  2);
        queue_request(KIND_READ,  17'h00800,  1);
        queue_request(KIND_WRITE, 17'd0,      3);
        queue_request(KIND_WRITE, 17'h00800,  0);
        queue_request(KIND_READ,  17'h1F800,  4);
        queue_request(KIND_WRITE, 17'h15555,  5);
        queue_request(KIND_READ,  17'h15555,  0);
        queue_request(KIND_READ,  17'h0AAAA,  2);
        queue_request(KIND_WRITE, 17'h0AAAA,  0);
        queue_request(KIND_READ,  17'h0AAAA,  1);

        // Random part: mostly writes and re-reads around a few busy L1 entries.
        for (int i = 0; i < 8; i++) begin
            hot_l1[i] = L1I_W'($urandom_range(0, L1_ENTRIES - 1));
        end
        hot_l1[0] = '0;
        hot_l1[7] = '1;
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            pick = $urandom_range(0, 9);
            gap  = ((i % 120) < 30) ? 0 : $urandom_range(0, 5);
            if (pick < 2) begin
                k = kind_t'($urandom_range(0, 1));
                a = ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
            end else if (pick < 6 || written.size() == 0) begin
                k = KIND_WRITE;
                a = {hot_l1[$urandom_range(0, 7)], 11'($urandom)};
                written.push_back(a);
            end else if (pick < 9) begin
                k = KIND_READ;
                a = written[$urandom_range(0, written.size() - 1)];
                if ($urandom_range(0, 1) == 1) begin
                    a[BIS_W-1:0] = BIS_W'($urandom);
                end
            end else begin
                k = KIND_READ;
                a = {hot_l1[$urandom_range(0, 7)], 11'($urandom)};
            end
            queue_request(k, a, gap);
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_requests.size() > 0 || s_valid) @(negedge aclk);
        while (expected_results.size() > 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Run covered %0d requests (%0d writes) and %0d results.",
                 n_sent, n_writes, n_results);
        $display("Map state at end: %0d L2 tables and %0d data slots in use.",
                 tables_used, int'(slots_next) - 1);
        if (mismatches == 0) begin
            $display("[cow_block_map_top] OK");
        end else begin
            $display("[cow_block_map_top] ERROR");
        end
        $finish;
    end

endmodule
